// ===== hw/rtl/gbba_pkg.sv =====
// Shared types and constants of the grouped bitmap block allocator.
package gbba_pkg;

	localparam int MAX_GROUPS_DEF = 16;
	localparam int GROUP_BITS_DEF = 1024;

	localparam int KIND_W  = 3;
	localparam int GRP_W   = 4;
	localparam int BLK_W   = 15;
	localparam int WIDX_W  = 8;
	localparam int WORD_W  = 64;
	localparam int CNT_W   = 15;
	localparam int GFREE_W = 11;
	localparam int BPG_W   = 11;
	localparam int GC_W    = 5;
	localparam int CFG_W   = 15;
	localparam int CIDX_W  = 3;

	localparam logic [GFREE_W-1:0] GROUP_FREE_MAX = '1;
	localparam logic [CNT_W-1:0]   TOTAL_FREE_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		K_ALLOC = 3'd0,
		K_FREE  = 3'd1,
		K_LDW   = 3'd2,
		K_LDG   = 3'd3,
		K_LDT   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_READ_ONLY = 2'd2,
		ST_NO_SPACE  = 2'd3
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		R_READ_ONLY = 3'd0,
		R_GROUP_CNT = 3'd1,
		R_BPG       = 3'd2,
		R_TOTAL     = 3'd3,
		R_FIRST     = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECIDE, S_GROUP, S_RDWAIT, S_SCAN, S_SETBIT,
		S_DIV, S_FREEBIT, S_FREEWR, S_LDW, S_DONE
	} state_t;

	// Divider request/response between sequencer and divider
	typedef struct packed {
		logic             start;
		logic [BLK_W-1:0] dividend;
		logic [BPG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [BLK_W-1:0] quot;
		logic [BLK_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== hw/rtl/grouped_bitmap_block_allocator.sv =====
// Grouped bitmap block allocator: top level with sequencer and free counts.
//
// Usage: items enter on s_axis (tdata: kind, group, block_number, word_index,
// word_data, count_value) and one result leaves on m_axis per item (tdata:
// status, allocated_block, group_table_dirty, total_dirty). Registers are
// written through cfg_we/cfg_idx/cfg_data, by the user only while the block
// is idle; the block itself does not enforce this. After reset a clearing pass
// writes zero to every bitmap word, one word per cycle, MAX_GROUPS*GROUP_BITS/64
// words in all (256 by default); s_axis_tready stays low meanwhile.
// One item is handled at a time. A count load passes a decide state and a
// done state before its result; a bitmap word load writes its word between
// them. A free runs a 15-step bit-serial divide, then a read and a write of
// one bitmap word. An allocate first reduces the preferred group by repeated
// subtraction of the group count, then walks the groups round-robin and reads
// their bitmap words one per cycle through the single memory port.
// The result waits in an output register; while m_axis_tready is low the
// block holds it and takes no new item.
module grouped_bitmap_block_allocator #(
	parameter int MAX_GROUPS = gbba_pkg::MAX_GROUPS_DEF,
	parameter int GROUP_BITS = gbba_pkg::GROUP_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// kind[2:0], group[6:3], block_number[21:7], word_index[29:22],
	// word_data[93:30], count_value[108:94], zero fill
	input  logic [111:0]                 s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// status[1:0], allocated_block[16:2], group_table_dirty[17], total_dirty[18]
	output logic [23:0]                  m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [gbba_pkg::CIDX_W-1:0]  cfg_idx,
	input  logic [gbba_pkg::CFG_W-1:0]   cfg_data
);
	import gbba_pkg::*;

	localparam int WPG   = GROUP_BITS / 64;
	localparam int DEPTH = MAX_GROUPS * WPG;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WB    = (WPG > 1) ? $clog2(WPG) : 1;
	localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCW   = $clog2(MAX_GROUPS + 1);

	// Input fields
	logic [KIND_W-1:0] in_kind;
	logic [GRP_W-1:0]  in_group;
	logic [BLK_W-1:0]  in_blk;
	logic [WIDX_W-1:0] in_widx;
	logic [WORD_W-1:0] in_wdata;
	logic [CNT_W-1:0]  in_cnt;
	assign in_kind  = s_axis_tdata[2:0];
	assign in_group = s_axis_tdata[6:3];
	assign in_blk   = s_axis_tdata[21:7];
	assign in_widx  = s_axis_tdata[29:22];
	assign in_wdata = s_axis_tdata[93:30];
	assign in_cnt   = s_axis_tdata[108:94];

	// Configuration registers
	logic              ro_q;
	logic [GC_W-1:0]   gc_q;
	logic [BPG_W-1:0]  bpg_q;
	logic [BLK_W-1:0]  tb_q;
	logic              fdb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q  <= 1'b0;
			gc_q  <= GC_W'(1);
			bpg_q <= BPG_W'(1024);
			tb_q  <= BLK_W'(1024);
			fdb_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				R_READ_ONLY: ro_q  <= cfg_data[0];
				R_GROUP_CNT: gc_q  <= cfg_data[GC_W-1:0];
				R_BPG:       bpg_q <= cfg_data[BPG_W-1:0];
				R_TOTAL:     tb_q  <= cfg_data[BLK_W-1:0];
				R_FIRST:     fdb_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective group count and group size
	logic [GCW-1:0]    ng;
	logic [BPG_W+3:0]  bpg;
	always_comb begin
		if (gc_q == '0) ng = GCW'(1);
		else if (32'(gc_q) > MAX_GROUPS) ng = GCW'(MAX_GROUPS);
		else ng = GCW'(gc_q);
		if (bpg_q == '0) bpg = (BPG_W+4)'(1);
		else if (32'(bpg_q) > GROUP_BITS) bpg = (BPG_W+4)'(GROUP_BITS);
		else bpg = (BPG_W+4)'(bpg_q);
	end

	// State
	state_t            st_q, st_d;
	logic [GFREE_W-1:0] gfree_q [MAX_GROUPS];
	logic [CNT_W-1:0]  tfree_q;
	logic              gdirty_q, tdirty_q;
	logic [AW-1:0]     clr_q;
	logic [KIND_W-1:0] kind_q;
	logic [GW-1:0]     grp_q;
	logic              grp_ok_q;
	logic [GCW-1:0]    tried_q;
	logic [WB-1:0]     wcnt_q;
	logic [BLK_W+3:0]  base_q;
	logic [BLK_W+3:0]  size_q;
	logic [BLK_W-1:0]  blk_q;
	logic [WORD_W-1:0] word_q;
	logic [AW-1:0]     waddr_q;
	logic [5:0]        bidx_q;
	logic [BLK_W-1:0]  fblk_q;
	logic [WIDX_W-1:0] widx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BLK_W-1:0]  relb_q;
	logic [GW-1:0]     fgrp_q;
	logic [1:0]        status_q;
	logic              ovalid_q;
	logic [BLK_W-1:0]  oblk_q;

	// Memory port
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	gbba_bitmap #(.DEPTH(DEPTH), .AW(AW)) u_bitmap (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);

	// Divider
	div_req_t dreq;
	div_rsp_t drsp;
	gbba_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic accept;
	assign s_axis_tready = (st_q == S_IDLE) && !ovalid_q;
	assign accept = s_axis_tvalid && s_axis_tready;

	// Lowest clear bit in the word read back, within group size
	logic [BLK_W+3:0] wbase;
	logic [WORD_W-1:0] avail;
	logic              hit;
	logic [5:0]        hit_idx;
	always_comb begin
		wbase = (BLK_W+4)'(wcnt_q) << 6;
		for (int i = 0; i < WORD_W; i++) begin
			avail[i] = !mem_rdata[i] && ((wbase + (BLK_W+4)'(i)) < size_q);
		end
		hit = |avail;
		hit_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (avail[i]) hit_idx = 6'(i);
		end
	end

	// Size of group grp_q
	logic [BLK_W+3:0] gsize;
	logic [BLK_W+3:0] lead;
	always_comb begin
		lead = (BLK_W+4)'(fdb_q) + base_q;
		if (GCW'(grp_q) != ng - GCW'(1)) gsize = bpg;
		else if ((BLK_W+4)'(tb_q) <= lead) gsize = '0;
		else if (((BLK_W+4)'(tb_q) - lead) < bpg) gsize = (BLK_W+4)'(tb_q) - lead;
		else gsize = bpg;
	end

	logic [GW-1:0] grp_next;
	assign grp_next = (GCW'(grp_q) + GCW'(1) >= ng) ? '0 : grp_q + GW'(1);

	logic [BLK_W+3:0] bit_in_grp;
	assign bit_in_grp = (BLK_W+4)'(relb_q);

	// Next state and datapath controls
	always_comb begin
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_addr  = clr_q;
		mem_wdata = '0;
		dreq.start    = 1'b0;
		dreq.dividend = fblk_q - BLK_W'(fdb_q);
		dreq.divisor  = bpg[BPG_W-1:0];
		unique case (st_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (32'(clr_q) == DEPTH - 1) st_d = S_IDLE;
			end
			S_IDLE: if (accept) st_d = S_DECIDE;
			S_DECIDE: begin
				case (kind_q)
					K_ALLOC: begin
						if (GCW'(grp_q) >= ng) st_d = S_DECIDE;
						else st_d = (ro_q || tfree_q == '0) ? S_DONE : S_GROUP;
					end
					K_FREE: begin
						if (ro_q || fblk_q < BLK_W'(fdb_q)) st_d = S_DONE;
						else begin
							dreq.start = 1'b1;
							st_d = S_DIV;
						end
					end
					K_LDW: st_d = S_LDW;
					default: st_d = S_DONE;
				endcase
			end
			S_GROUP: begin
				if (tried_q >= ng) st_d = S_DONE;
				else if (gfree_q[grp_q] == '0 || gsize == '0) st_d = S_GROUP;
				else begin
					mem_addr = AW'(32'(grp_q) * WPG);
					st_d = S_RDWAIT;
				end
			end
			S_RDWAIT: begin
				mem_addr = waddr_q;
				st_d = S_SCAN;
			end
			S_SCAN: begin
				mem_addr = waddr_q + AW'(1);
				if (hit) st_d = S_SETBIT;
				else if (32'(wcnt_q) == WPG - 1 || (wbase + 64) >= size_q) st_d = S_GROUP;
			end
			S_SETBIT: begin
				mem_we = 1'b1;
				mem_addr = waddr_q;
				mem_wdata = word_q | (WORD_W'(1) << bidx_q);
				st_d = S_DONE;
			end
			S_DIV: begin
				if (drsp.done) st_d = S_FREEBIT;
			end
			S_FREEBIT: begin
				mem_addr = AW'(32'(fgrp_q) * WPG) + AW'(bit_in_grp >> 6);
				st_d = (32'(drsp.quot) >= 32'(ng)) ? S_DONE : S_FREEWR;
			end
			S_FREEWR: begin
				mem_addr = AW'(32'(fgrp_q) * WPG) + AW'(bit_in_grp >> 6);
				mem_we = 1'b1;
				mem_wdata = mem_rdata & ~(WORD_W'(1) << bit_in_grp[5:0]);
				st_d = S_DONE;
			end
			S_LDW: begin
				mem_addr = AW'(widx_q);
				mem_we = (32'(widx_q) < DEPTH);
				mem_wdata = word_q;
				st_d = S_DONE;
			end
			S_DONE: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_CLEAR;
		else st_q <= st_d;
	end

	// Control registers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			tfree_q  <= '0;
			gdirty_q <= 1'b0;
			tdirty_q <= 1'b0;
			ovalid_q <= 1'b0;
			for (int g = 0; g < MAX_GROUPS; g++) gfree_q[g] <= '0;
		end else begin
			if (st_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
			if (st_q == S_DONE) ovalid_q <= 1'b1;
			if (st_q == S_DECIDE && kind_q == K_LDG && grp_ok_q)
				gfree_q[grp_q] <= (cnt_q > CNT_W'(GROUP_FREE_MAX)) ? GROUP_FREE_MAX
					: cnt_q[GFREE_W-1:0];
			if (st_q == S_DECIDE && kind_q == K_LDT) tfree_q <= cnt_q;
			if (st_q == S_SETBIT) begin
				gfree_q[grp_q] <= gfree_q[grp_q] - GFREE_W'(1);
				tfree_q  <= tfree_q - CNT_W'(1);
				gdirty_q <= 1'b1;
				tdirty_q <= 1'b1;
			end
			if (st_q == S_FREEWR) begin
				if (gfree_q[fgrp_q] != GROUP_FREE_MAX)
					gfree_q[fgrp_q] <= gfree_q[fgrp_q] + GFREE_W'(1);
				if (tfree_q != TOTAL_FREE_MAX) tfree_q <= tfree_q + CNT_W'(1);
				gdirty_q <= 1'b1;
				tdirty_q <= 1'b1;
			end
		end
	end

	// Item payload and search registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= in_kind;
			grp_q    <= GW'(in_group);
			grp_ok_q <= (32'(in_group) < MAX_GROUPS);
			fblk_q   <= in_blk;
			widx_q   <= in_widx;
			word_q   <= in_wdata;
			cnt_q    <= in_cnt;
			tried_q  <= '0;
			status_q <= ST_INVALID;
			oblk_q   <= '0;
		end
		unique case (st_q)
			S_DECIDE: begin
				// Reduce the preferred group below the group count, one subtract a cycle
				if (kind_q == K_ALLOC && GCW'(grp_q) >= ng)
					grp_q <= grp_q - GW'(ng);
				base_q <= (BLK_W+4)'(32'(grp_q) * 32'(bpg));
				case (kind_q)
					K_ALLOC: status_q <= ro_q ? ST_READ_ONLY : ST_NO_SPACE;
					K_FREE:  status_q <= ro_q ? ST_READ_ONLY : ST_INVALID;
					K_LDW:   status_q <= (32'(widx_q) < DEPTH) ? ST_OK : ST_INVALID;
					K_LDG:   status_q <= grp_ok_q ? ST_OK : ST_INVALID;
					K_LDT:   status_q <= ST_OK;
					default: status_q <= ST_INVALID;
				endcase
			end
			S_GROUP: begin
				wcnt_q  <= '0;
				size_q  <= gsize;
				waddr_q <= AW'(32'(grp_q) * WPG);
				if (!(tried_q < ng && gfree_q[grp_q] != '0 && gsize != '0)) begin
					grp_q   <= grp_next;
					base_q  <= (BLK_W+4)'(32'(grp_next) * 32'(bpg));
					tried_q <= tried_q + GCW'(1);
				end
			end
			S_SCAN: begin
				word_q <= mem_rdata;
				bidx_q <= hit_idx;
				if (hit) begin
					status_q <= ST_OK;
					oblk_q <= BLK_W'((BLK_W+4)'(fdb_q) + base_q + wbase + (BLK_W+4)'(hit_idx));
				end else begin
					waddr_q <= waddr_q + AW'(1);
					wcnt_q  <= wcnt_q + WB'(1);
					if (32'(wcnt_q) == WPG - 1 || (wbase + 64) >= size_q) begin
						grp_q   <= grp_next;
						base_q  <= (BLK_W+4)'(32'(grp_next) * 32'(bpg));
						tried_q <= tried_q + GCW'(1);
					end
				end
			end
			S_DIV: begin
				relb_q <= drsp.rem;
				fgrp_q <= GW'(drsp.quot);
			end
			S_FREEWR: status_q <= ST_OK;
			default: ;
		endcase
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, tdirty_q, gdirty_q, oblk_q, status_q};
endmodule

// ===== hw/rtl/gbba_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gbba_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gbba_pkg::div_req_t req,
	output gbba_pkg::div_rsp_t rsp
);
	import gbba_pkg::*;

	logic [BLK_W-1:0]  quot_q;
	logic [BLK_W:0]    rem_q;
	logic [BPG_W-1:0]  dvs_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [BLK_W:0]    trial;
	logic [BLK_W:0]    shifted;

	// Shift in next dividend bit, try subtract
	always_comb begin
		shifted = {rem_q[BLK_W-1:0], quot_q[BLK_W-1]};
		trial   = shifted - {{(BLK_W+1-BPG_W){1'b0}}, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(BLK_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (!trial[BLK_W]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[BLK_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[BLK_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q[BLK_W-1:0];
endmodule

// ===== hw/rtl/gbba_bitmap.sv =====
// Usage bitmap memory, one read or write port per cycle, registered read data.
module gbba_bitmap #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              addr,
	input  logic [gbba_pkg::WORD_W-1:0] wdata,
	output logic [gbba_pkg::WORD_W-1:0] rdata
);
	import gbba_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	// Write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/gbba_checker.sv =====
// Port-level checks on the allocator, bound to the top level.
module gbba_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [23:0]  m_axis_tdata
);
	import gbba_pkg::*;

	// Result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// No new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("ready while result pending");

	// One item at a time: not ready right after an accepted item
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after accept");

	// A result that is not OK carries no block
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[16:2] == '0)
		else $error("block on failure");

	// Group table dirty flag never falls
	a_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tdata[17]) && $past(arst_n) |-> m_axis_tdata[17])
		else $error("dirty flag fell");
endmodule

bind grouped_bitmap_block_allocator gbba_checker u_gbba_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
